// ===== design/rhhi_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhhi_pkg
// Shared constants, opcodes and types of the Robin Hood hash index.
// ----------------------------------------------------------------------------
package rhhi_pkg;

    localparam int LOG2_MAX_ENTRIES_DEF = 10;
    localparam int CAP_W   = 4;
    localparam int CAP_RST = 10;
    localparam int KEY_W   = 64;
    localparam int VAL_W   = 64;
    localparam int COUNT_W = 11;

    localparam logic [1:0] MODE_LOOKUP = 2'd0;
    localparam logic [1:0] MODE_INSERT = 2'd1;
    localparam logic [1:0] MODE_RMKEY  = 2'd2;
    localparam logic [1:0] MODE_RMVAL  = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_INVALID  = 2'd3;

    // classified command from the front part to the back part
    typedef struct packed {
        logic [1:0]       mode;
        logic             bad;   // insert of zero
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] val;
    } t_cmd;

endpackage

// ===== design/rhhi_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhhi_front
// Accepts operation words, flags an insert of zero and queues them for the
// table engine in a two-entry queue.
// ----------------------------------------------------------------------------
module rhhi_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [1:0]                       i_mode,
    input  logic [rhhi_pkg::KEY_W-1:0]       i_key_hash,
    input  logic [rhhi_pkg::VAL_W-1:0]       i_value,
    output logic                             o_cmd_valid,
    input  logic                             i_cmd_ready,
    output rhhi_pkg::t_cmd                   o_cmd
);
    rhhi_pkg::t_cmd r_q [2];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt;
    logic           w_push, w_pop;
    rhhi_pkg::t_cmd w_new;

    assign o_ready     = (r_cnt != 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign w_push      = i_valid && o_ready;
    assign w_pop       = o_cmd_valid && i_cmd_ready;

    always_comb begin
        w_new.mode = i_mode;
        w_new.bad  = (i_mode == rhhi_pkg::MODE_INSERT) && (i_value == '0);
        w_new.key  = i_key_hash;
        w_new.val  = i_value;
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_new;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end
endmodule

// ===== design/rhhi_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhhi_back
// Table engine: one slot read per probe step, sequenced by a state machine,
// with a clearing sweep after reset and after each capacity write.
// ----------------------------------------------------------------------------
module rhhi_back #(
    parameter int LOG2_MAX_ENTRIES = rhhi_pkg::LOG2_MAX_ENTRIES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              cfg_we,
    input  logic [rhhi_pkg::CAP_W-1:0]        cfg_wdata,
    input  logic                              i_cmd_valid,
    output logic                              o_cmd_ready,
    input  rhhi_pkg::t_cmd                    i_cmd,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [1:0]                        o_status,
    output logic [rhhi_pkg::VAL_W-1:0]        o_value_out,
    output logic                              o_changed,
    output logic [rhhi_pkg::COUNT_W-1:0]      o_entry_count
);
    localparam int AW    = LOG2_MAX_ENTRIES;
    localparam int DEPTH = 1 << AW;
    localparam int NW    = AW + 1;
    localparam int RST_L = (AW < rhhi_pkg::CAP_RST) ? AW : rhhi_pkg::CAP_RST;
    localparam logic [AW-1:0] RST_MASK = AW'((1 << RST_L) - 1);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_RD    = 4'd2;   // issue read of r_pos
    localparam logic [3:0] S_PROBE = 4'd3;   // read data of r_pos valid
    localparam logic [3:0] S_SRD   = 4'd4;   // shift: read next slot
    localparam logic [3:0] S_SHIFT = 4'd5;
    localparam logic [3:0] S_SCAN  = 4'd6;   // remove by value scan
    localparam logic [3:0] S_OUT   = 4'd7;

    logic [rhhi_pkg::KEY_W-1:0] r_mkey [DEPTH];
    logic [rhhi_pkg::VAL_W-1:0] r_mval [DEPTH];
    logic [rhhi_pkg::KEY_W-1:0] r_rkey;
    logic [rhhi_pkg::VAL_W-1:0] r_rval;

    logic [3:0]                 r_state;
    logic [AW-1:0]              r_mask;
    logic [AW-1:0]              r_pos, r_home;
    logic [NW-1:0]              r_n;
    logic [1:0]                 r_mode;
    logic                       r_scan_rm;
    logic [rhhi_pkg::KEY_W-1:0] r_ck;
    logic [rhhi_pkg::VAL_W-1:0] r_cv;
    logic [rhhi_pkg::COUNT_W-1:0] r_count;
    logic [1:0]                 r_status;
    logic [rhhi_pkg::VAL_W-1:0] r_vout;
    logic                       r_changed;

    // write port
    logic                       w_we;
    logic [AW-1:0]              w_wa;
    logic [rhhi_pkg::KEY_W-1:0] w_wk;
    logic [rhhi_pkg::VAL_W-1:0] w_wv;
    logic [AW-1:0]              w_ra;

    logic [AW-1:0] w_mask_new;
    logic [AW-1:0] w_nxt, w_rhome, w_dist_c, w_dist_r;
    logic          w_end;

    always_comb begin
        logic [rhhi_pkg::CAP_W-1:0] l;
        l = cfg_wdata;
        if (l < 4'd1) l = 4'd1;
        if ({{(32-rhhi_pkg::CAP_W){1'b0}}, l} > 32'(AW)) l = rhhi_pkg::CAP_W'(AW);
        w_mask_new = AW'(({{(AW-1){1'b0}}, 1'b1} << l) - 1'b1);
    end

    assign w_nxt    = (r_pos + 1'b1) & r_mask;
    assign w_rhome  = r_rkey[AW-1:0] & r_mask;
    assign w_dist_c = (r_pos - r_home) & r_mask;
    assign w_dist_r = (r_pos - w_rhome) & r_mask;
    assign w_end    = (r_n == {1'b0, r_mask});

    assign o_cmd_ready  = (r_state == S_IDLE) && !cfg_we;
    assign o_valid      = (r_state == S_OUT);
    assign o_status     = r_status;
    assign o_value_out  = r_vout;
    assign o_changed    = r_changed;
    assign o_entry_count = r_count;

    // read address: next probe slot chosen combinationally
    always_comb begin
        w_ra = r_pos;
        if (r_state == S_SRD) w_ra = w_nxt;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mkey[w_wa] <= w_wk;
            r_mval[w_wa] <= w_wv;
        end
        r_rkey <= r_mkey[w_ra];
        r_rval <= r_mval[w_ra];
    end

    always_comb begin
        w_we = 1'b0;
        w_wa = r_pos;
        w_wk = r_ck;
        w_wv = r_cv;
        unique case (r_state)
            S_CLEAR: begin
                w_we = 1'b1;
                w_wk = '0;
                w_wv = '0;
            end
            S_PROBE: begin
                if (r_mode == rhhi_pkg::MODE_INSERT) begin
                    if (r_rval == '0 || r_rkey == r_ck) begin
                        w_we = 1'b1;
                    end else if (w_dist_c > w_dist_r) begin
                        w_we = 1'b1;
                    end
                end
            end
            S_SHIFT: begin
                w_we = 1'b1;
                if (r_rval == '0 || ((w_nxt - w_rhome) & r_mask) == '0
                        || w_end) begin
                    w_wk = '0;
                    w_wv = '0;
                end else begin
                    w_wk = r_rkey;
                    w_wv = r_rval;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_mask    <= RST_MASK;
            r_pos     <= '0;
            r_count   <= '0;
            r_changed <= 1'b0;
            r_status  <= rhhi_pkg::ST_OK;
            r_vout    <= '0;
        end else if (cfg_we) begin
            // capacity write: restart the clearing sweep
            r_mask  <= w_mask_new;
            r_state <= S_CLEAR;
            r_pos   <= '0;
            r_count <= '0;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    if (r_pos == AW'(DEPTH - 1)) begin
                        r_state <= S_IDLE;
                        r_pos   <= '0;
                    end else begin
                        r_pos <= r_pos + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_mode    <= i_cmd.mode;
                        r_ck      <= i_cmd.key;
                        r_cv      <= i_cmd.val;
                        r_n       <= '0;
                        r_vout    <= '0;
                        r_changed <= 1'b0;
                        r_scan_rm <= 1'b0;
                        r_home    <= i_cmd.key[AW-1:0] & r_mask;
                        if (i_cmd.mode == rhhi_pkg::MODE_RMVAL)
                            r_pos <= '0;
                        else
                            r_pos <= i_cmd.key[AW-1:0] & r_mask;
                        if (i_cmd.bad) begin
                            r_status <= rhhi_pkg::ST_INVALID;
                            r_state  <= S_OUT;
                        end else begin
                            r_status <= rhhi_pkg::ST_OK;
                            if (i_cmd.mode == rhhi_pkg::MODE_RMVAL && i_cmd.val == '0)
                                r_state <= S_OUT;
                            else
                                r_state <= S_RD;
                        end
                    end
                end
                S_RD: begin
                    if (r_mode == rhhi_pkg::MODE_RMVAL && !r_scan_rm)
                        r_state <= S_SCAN;
                    else
                        r_state <= S_PROBE;
                end
                S_SCAN: begin
                    if (r_rval == r_cv) begin
                        // found: remove by its key from its home
                        r_scan_rm <= 1'b1;
                        r_ck      <= r_rkey;
                        r_home    <= r_rkey[AW-1:0] & r_mask;
                        r_pos     <= r_rkey[AW-1:0] & r_mask;
                        r_n       <= '0;
                        r_state   <= S_RD;
                    end else if (w_end) begin
                        r_state <= S_OUT;
                    end else begin
                        r_pos   <= w_nxt;
                        r_n     <= r_n + 1'b1;
                        r_state <= S_RD;
                    end
                end
                S_PROBE: begin
                    if (r_mode == rhhi_pkg::MODE_INSERT) begin
                        if (r_rval == '0) begin
                            r_count   <= r_count + 1'b1;
                            r_changed <= 1'b1;
                            r_state   <= S_OUT;
                        end else if (r_rkey == r_ck) begin
                            r_state <= S_OUT;
                        end else begin
                            if (w_dist_c > w_dist_r) begin
                                r_ck   <= r_rkey;
                                r_cv   <= r_rval;
                                r_home <= w_rhome;
                            end
                            if (w_end) begin
                                r_status <= rhhi_pkg::ST_FULL;
                                r_state  <= S_OUT;
                            end else begin
                                r_pos   <= w_nxt;
                                r_n     <= r_n + 1'b1;
                                r_state <= S_RD;
                            end
                        end
                    end else begin
                        // lookup or remove by key (also after a value scan)
                        if (r_rval == '0 || (w_end && r_rkey != r_ck)) begin
                            if (!r_scan_rm) r_status <= rhhi_pkg::ST_NOTFOUND;
                            r_state <= S_OUT;
                        end else if (r_rkey == r_ck) begin
                            if (r_mode == rhhi_pkg::MODE_LOOKUP) begin
                                r_vout  <= r_rval;
                                r_state <= S_OUT;
                            end else begin
                                r_n     <= '0;
                                r_state <= S_SRD;
                            end
                        end else begin
                            r_pos   <= w_nxt;
                            r_n     <= r_n + 1'b1;
                            r_state <= S_RD;
                        end
                    end
                end
                S_SRD: begin
                    r_state <= S_SHIFT;
                end
                S_SHIFT: begin
                    if (r_rval == '0 || ((w_nxt - w_rhome) & r_mask) == '0
                            || w_end) begin
                        if (r_count != '0) r_count <= r_count - 1'b1;
                        r_changed <= 1'b1;
                        r_state   <= S_OUT;
                    end else begin
                        r_pos   <= w_nxt;
                        r_n     <= r_n + 1'b1;
                        r_state <= S_SRD;
                    end
                end
                S_OUT: begin
                    if (i_ready) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== design/robin_hood_hash_index_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// robin_hood_hash_index_unit
// Open-addressed Robin Hood hash index with backward-shift deletion.
// One word is in the engine at a time; the next leaves the queue once the
// engine has gone from its result state back to idle after the result word
// is taken. A backward shift ends with a step that clears the vacated slot.
// Reset and every capacity write run a clearing sweep over all
// 2^LOG2_MAX_ENTRIES slots, during which no word is taken from the queue.
// ----------------------------------------------------------------------------
module robin_hood_hash_index_unit #(
    parameter int LOG2_MAX_ENTRIES = rhhi_pkg::LOG2_MAX_ENTRIES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              cfg_we,
    input  logic [rhhi_pkg::CAP_W-1:0]        cfg_wdata,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [1:0]                        i_mode,
    input  logic [rhhi_pkg::KEY_W-1:0]        i_key_hash,
    input  logic [rhhi_pkg::VAL_W-1:0]        i_value,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [1:0]                        o_status,
    output logic [rhhi_pkg::VAL_W-1:0]        o_value_out,
    output logic                              o_changed,
    output logic [rhhi_pkg::COUNT_W-1:0]      o_entry_count
);
    logic           w_cmd_valid, w_cmd_ready;
    rhhi_pkg::t_cmd w_cmd;

    // front: accept and classify words, queue them
    rhhi_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_mode, .i_key_hash, .i_value,
        .o_cmd_valid(w_cmd_valid), .i_cmd_ready(w_cmd_ready), .o_cmd(w_cmd)
    );

    // back: probe, insert, shift and report
    rhhi_back #(.LOG2_MAX_ENTRIES(LOG2_MAX_ENTRIES)) u_back (
        .i_clk, .i_rst_n, .cfg_we, .cfg_wdata,
        .i_cmd_valid(w_cmd_valid), .o_cmd_ready(w_cmd_ready), .i_cmd(w_cmd),
        .o_valid, .i_ready, .o_status, .o_value_out, .o_changed, .o_entry_count
    );
endmodule

// ===== design/rhhi_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhhi_port_checker
// Port-level checks of the hash index, bound to the top level.
// ----------------------------------------------------------------------------
module rhhi_port_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_valid,
    input logic                          i_ready,
    input logic [1:0]                    o_status,
    input logic [rhhi_pkg::VAL_W-1:0]    o_value_out,
    input logic                          o_changed,
    input logic [rhhi_pkg::COUNT_W-1:0]  o_entry_count
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status))
        else $error("result dropped while stalled");
    a_vout: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != rhhi_pkg::ST_OK |-> o_value_out == '0)
        else $error("value on failure");
    a_chg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_changed |-> o_status == rhhi_pkg::ST_OK)
        else $error("change with error status");
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_changed |-> o_entry_count <= 11'd1024)
        else $error("count out of range");
endmodule

bind robin_hood_hash_index_unit rhhi_port_checker u_chk (
    .i_clk, .i_rst_n, .o_valid, .i_ready, .o_status, .o_value_out,
    .o_changed, .o_entry_count
);

// ===== sim/rhhi_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhhi_checker
// Watches both channels and the capacity port of the hash index, keeps its
// own copy of the table and compares each result word with the prediction.
// ----------------------------------------------------------------------------
module rhhi_checker #(
    parameter int LOG2_MAX = rhhi_pkg::LOG2_MAX_ENTRIES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         cfg_we,
    input  logic [rhhi_pkg::CAP_W-1:0]   cfg_wdata,
    input  logic                         i_valid,
    input  logic                         o_ready,
    input  logic [1:0]                   i_mode,
    input  logic [rhhi_pkg::KEY_W-1:0]   i_key_hash,
    input  logic [rhhi_pkg::VAL_W-1:0]   i_value,
    input  logic                         o_valid,
    input  logic                         i_ready,
    input  logic [1:0]                   o_status,
    input  logic [rhhi_pkg::VAL_W-1:0]   o_value_out,
    input  logic                         o_changed,
    input  logic [rhhi_pkg::COUNT_W-1:0] o_entry_count,
    output int                           o_errors,
    output int                           o_pending
);

    localparam int DEPTH = 1 << LOG2_MAX;

    typedef struct packed {
        logic [1:0]                   status;
        logic [rhhi_pkg::VAL_W-1:0]   value_out;
        logic                         changed;
        logic [rhhi_pkg::COUNT_W-1:0] entry_count;
    } t_result;

    logic [rhhi_pkg::KEY_W-1:0] tbl_key [DEPTH];
    logic [rhhi_pkg::VAL_W-1:0] tbl_val [DEPTH];
    int                         live_entries;
    logic [rhhi_pkg::CAP_W-1:0] cap_log2;
    t_result                    result_queue[$];

    function automatic int slot_mask();
        int l;
        l = cap_log2;
        if (l < 1) l = 1;
        if (l > LOG2_MAX) l = LOG2_MAX;
        return (1 << l) - 1;
    endfunction

    function automatic void wipe_table();
        for (int i = 0; i < DEPTH; i++) begin
            tbl_key[i] = '0;
            tbl_val[i] = '0;
        end
        live_entries = 0;
    endfunction

    function automatic bit delete_key(logic [rhhi_pkg::KEY_W-1:0] key, int mask);
        int pos;
        int nx;
        bit hit;
        pos = int'(key[31:0]) & mask;
        hit = 0;
        for (int n = 0; n <= mask; n++) begin
            if (tbl_val[pos] == '0) return 0;
            if (tbl_key[pos] == key) begin
                hit = 1;
                break;
            end
            pos = (pos + 1) & mask;
        end
        if (!hit) return 0;
        // backward shift: pull followers until an empty slot or one at home
        for (int n = 0; n < mask; n++) begin
            nx = (pos + 1) & mask;
            if (tbl_val[nx] == '0) break;
            if (((nx - (int'(tbl_key[nx][31:0]) & mask)) & mask) == 0) break;
            tbl_key[pos] = tbl_key[nx];
            tbl_val[pos] = tbl_val[nx];
            pos = nx;
        end
        tbl_key[pos] = '0;
        tbl_val[pos] = '0;
        if (live_entries > 0) live_entries--;
        return 1;
    endfunction

    function automatic t_result predict_result(logic [1:0] mode,
                                               logic [rhhi_pkg::KEY_W-1:0] key,
                                               logic [rhhi_pkg::VAL_W-1:0] val);
        t_result r;
        int mask;
        int pos;
        int chome;
        logic [rhhi_pkg::KEY_W-1:0] ck, tk;
        logic [rhhi_pkg::VAL_W-1:0] cv, tv;
        mask = slot_mask();
        r = '0;
        r.status = rhhi_pkg::ST_OK;
        case (mode)
            rhhi_pkg::MODE_LOOKUP: begin
                r.status = rhhi_pkg::ST_NOTFOUND;
                pos = int'(key[31:0]) & mask;
                for (int n = 0; n <= mask; n++) begin
                    if (tbl_val[pos] == '0) break;
                    if (tbl_key[pos] == key) begin
                        r.status = rhhi_pkg::ST_OK;
                        r.value_out = tbl_val[pos];
                        break;
                    end
                    pos = (pos + 1) & mask;
                end
            end
            rhhi_pkg::MODE_INSERT: begin
                if (val == '0) begin
                    r.status = rhhi_pkg::ST_INVALID;
                end else begin
                    ck = key;
                    cv = val;
                    chome = int'(key[31:0]) & mask;
                    pos = chome;
                    r.status = rhhi_pkg::ST_FULL;
                    for (int n = 0; n <= mask; n++) begin
                        if (tbl_val[pos] == '0) begin
                            tbl_key[pos] = ck;
                            tbl_val[pos] = cv;
                            live_entries++;
                            r.changed = 1'b1;
                            r.status = rhhi_pkg::ST_OK;
                            break;
                        end
                        if (tbl_key[pos] == ck) begin
                            tbl_val[pos] = cv;
                            r.status = rhhi_pkg::ST_OK;
                            break;
                        end
                        // swap with a resident that lies nearer its home
                        if (((pos - chome) & mask) >
                            ((pos - (int'(tbl_key[pos][31:0]) & mask)) & mask)) begin
                            tk = tbl_key[pos];
                            tv = tbl_val[pos];
                            tbl_key[pos] = ck;
                            tbl_val[pos] = cv;
                            ck = tk;
                            cv = tv;
                            chome = int'(ck[31:0]) & mask;
                        end
                        pos = (pos + 1) & mask;
                    end
                end
            end
            rhhi_pkg::MODE_RMKEY: begin
                r.changed = delete_key(key, mask);
                r.status = r.changed ? rhhi_pkg::ST_OK : rhhi_pkg::ST_NOTFOUND;
            end
            default: begin
                if (val != '0) begin
                    for (int i = 0; i <= mask; i++) begin
                        if (tbl_val[i] == val) begin
                            r.changed = delete_key(tbl_key[i], mask);
                            break;
                        end
                    end
                end
            end
        endcase
        r.entry_count = live_entries[rhhi_pkg::COUNT_W-1:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result got, want;
        if (!i_rst_n) begin
            cap_log2 = rhhi_pkg::CAP_W'(rhhi_pkg::CAP_RST);
            wipe_table();
            result_queue.delete();
        end else begin
            // compare first: a result word never belongs to the word taken now
            if (o_valid && i_ready) begin
                got = '{o_status, o_value_out, o_changed, o_entry_count};
                if (result_queue.size() == 0) begin
                    o_errors <= o_errors + 1;
                    if (o_errors < 10)
                        $display("%0t: result word with nothing expected: %h",
                                 $realtime, got);
                end else begin
                    want = result_queue.pop_front();
                    if (got !== want) begin
                        o_errors <= o_errors + 1;
                        if (o_errors < 10)
                            $display("%0t: mismatch status %0d/%0d value %h/%h chg %0d/%0d cnt %0d/%0d",
                                     $realtime, want.status, got.status, want.value_out,
                                     got.value_out, want.changed, got.changed,
                                     want.entry_count, got.entry_count);
                    end
                end
            end
            if (cfg_we) begin
                cap_log2 = cfg_wdata;
                wipe_table();
            end
            if (i_valid && o_ready)
                result_queue.push_back(predict_result(i_mode, i_key_hash, i_value));
        end
        o_pending = result_queue.size();
    end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives the hash index with directed and random operations across several
// capacities, with bursty input and a stalling receiver; a checker module
// predicts every result word and counts mismatches.
// ----------------------------------------------------------------------------
module tb;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         cfg_we = 1'b0;
    logic [rhhi_pkg::CAP_W-1:0]   cfg_wdata = '0;
    logic                         i_valid = 1'b0;
    logic                         o_ready;
    logic [1:0]                   i_mode = rhhi_pkg::MODE_LOOKUP;
    logic [rhhi_pkg::KEY_W-1:0]   i_key_hash = '0;
    logic [rhhi_pkg::VAL_W-1:0]   i_value = '0;
    logic                         o_valid;
    logic                         i_ready = 1'b0;
    logic [1:0]                   o_status;
    logic [rhhi_pkg::VAL_W-1:0]   o_value_out;
    logic                         o_changed;
    logic [rhhi_pkg::COUNT_W-1:0] o_entry_count;
    int                           mismatches;
    int                           outstanding;

    // key and value pools, so that random words hit live entries
    logic [rhhi_pkg::KEY_W-1:0]   key_pool[48];
    logic [rhhi_pkg::VAL_W-1:0]   val_pool[16];
    int                           burst_left = 0;
    int                           stall_style = 0;
    int                           stall_tick = 0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    robin_hood_hash_index_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .i_valid(i_valid), .o_ready(o_ready), .i_mode(i_mode),
        .i_key_hash(i_key_hash), .i_value(i_value), .o_valid(o_valid),
        .i_ready(i_ready), .o_status(o_status), .o_value_out(o_value_out),
        .o_changed(o_changed), .o_entry_count(o_entry_count)
    );

    rhhi_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .i_valid(i_valid), .o_ready(o_ready), .i_mode(i_mode),
        .i_key_hash(i_key_hash), .i_value(i_value), .o_valid(o_valid),
        .i_ready(i_ready), .o_status(o_status), .o_value_out(o_value_out),
        .o_changed(o_changed), .o_entry_count(o_entry_count),
        .o_errors(mismatches), .o_pending(outstanding)
    );

    // Receiver: switch between stall styles - none, coin toss or a periodic hole.
    always @(posedge i_clk) begin
        stall_tick <= stall_tick + 1;
        if (stall_tick % 200 == 0)
            stall_style <= $urandom_range(0, 2);
        case (stall_style)
            0: i_ready <= 1'b1;
            1: i_ready <= 1'($urandom_range(0, 1));
            default: i_ready <= (stall_tick % 3 != 0);
        endcase
    end

    // Present one word and hold it until taken; end the burst with a gap.
    task automatic send_word(logic [1:0] m, logic [rhhi_pkg::KEY_W-1:0] k,
                             logic [rhhi_pkg::VAL_W-1:0] v);
        i_valid    <= 1'b1;
        i_mode     <= m;
        i_key_hash <= k;
        i_value    <= v;
        do @(posedge i_clk); while (!o_ready);
        if (burst_left == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(0, 10);
        end else begin
            burst_left--;
        end
    endtask

    // Drain every outstanding result, then write a new capacity.
    task automatic set_capacity(logic [rhhi_pkg::CAP_W-1:0] c);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= c;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic random_phase(logic [rhhi_pkg::CAP_W-1:0] c, int count);
        int slots;
        int psize;
        int pick;
        logic [rhhi_pkg::KEY_W-1:0] k;
        logic [rhhi_pkg::VAL_W-1:0] v;
        logic [1:0] m;
        slots = 1 << ((c < 1) ? 1 : (c > 10) ? 10 : c);
        psize = (slots + slots / 2 + 1 > 48) ? 48 : slots + slots / 2 + 1;
        // cluster homes at low slots so probes and shifts get long
        for (int i = 0; i < 48; i++) begin
            key_pool[i] = rand64();
            if ($urandom_range(0, 3) != 0) key_pool[i][9:0] = 10'($urandom_range(0, 15));
        end
        for (int i = 0; i < 16; i++) val_pool[i] = rand64() | 64'd1;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 40)      m = rhhi_pkg::MODE_INSERT;
            else if (pick < 65) m = rhhi_pkg::MODE_LOOKUP;
            else if (pick < 85) m = rhhi_pkg::MODE_RMKEY;
            else                m = rhhi_pkg::MODE_RMVAL;
            k = ($urandom_range(0, 19) == 0) ? rand64() : key_pool[$urandom_range(0, psize - 1)];
            if ($urandom_range(0, 19) == 0)      v = '0;
            else if ($urandom_range(0, 2) != 0)  v = val_pool[$urandom_range(0, 15)];
            else                                 v = rand64();
            if (m == rhhi_pkg::MODE_INSERT && v != '0) val_pool[$urandom_range(0, 15)] = v;
            send_word(m, k, v);
        end
    endtask

    initial begin
        #100_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, full capacity after reset
        send_word(rhhi_pkg::MODE_LOOKUP, 64'd5, 64'd0);       // miss on empty table
        send_word(rhhi_pkg::MODE_INSERT, 64'd5, 64'd0);       // insert of zero
        send_word(rhhi_pkg::MODE_INSERT, 64'd0, '1);          // extreme key and value
        send_word(rhhi_pkg::MODE_INSERT, '1, 64'd1);
        send_word(rhhi_pkg::MODE_INSERT, 64'd0, 64'h1234);    // update present key
        send_word(rhhi_pkg::MODE_LOOKUP, 64'd0, 64'd0);       // hit
        send_word(rhhi_pkg::MODE_LOOKUP, '1, 64'd0);
        // chain of keys sharing one home, then drop the head to force a shift
        send_word(rhhi_pkg::MODE_INSERT, 64'h400, 64'd11);
        send_word(rhhi_pkg::MODE_INSERT, 64'h800, 64'd12);
        send_word(rhhi_pkg::MODE_INSERT, 64'd1, 64'd13);
        send_word(rhhi_pkg::MODE_RMKEY, 64'd0, 64'd0);
        send_word(rhhi_pkg::MODE_LOOKUP, 64'h800, 64'd0);
        send_word(rhhi_pkg::MODE_RMKEY, 64'h999, 64'd0);      // remove miss
        send_word(rhhi_pkg::MODE_RMVAL, 64'd0, 64'd0);        // remove value zero
        send_word(rhhi_pkg::MODE_RMVAL, 64'd0, 64'd77);       // value not present
        send_word(rhhi_pkg::MODE_RMVAL, 64'd0, 64'd12);       // value hit
        send_word(rhhi_pkg::MODE_LOOKUP, 64'h800, 64'd0);

        // smallest table: wrap to full, with a swap on the way
        set_capacity(4'd1);
        send_word(rhhi_pkg::MODE_INSERT, 64'd1, 64'd21);
        send_word(rhhi_pkg::MODE_INSERT, 64'd0, 64'd22);
        send_word(rhhi_pkg::MODE_INSERT, 64'd2, 64'd23);      // table full
        send_word(rhhi_pkg::MODE_LOOKUP, 64'd2, 64'd0);
        send_word(rhhi_pkg::MODE_RMKEY, 64'd1, 64'd0);
        send_word(rhhi_pkg::MODE_LOOKUP, 64'd0, 64'd0);

        random_phase(4'd1, 150);
        set_capacity(4'd2);  random_phase(4'd2, 180);
        set_capacity(4'd0);  random_phase(4'd0, 120);
        set_capacity(4'd3);  random_phase(4'd3, 220);
        set_capacity(4'd15); random_phase(4'd15, 220);
        set_capacity(4'd4);  random_phase(4'd4, 240);
        set_capacity(4'd6);  random_phase(4'd6, 200);
        set_capacity(4'd10); random_phase(4'd10, 220);

        i_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (mismatches == 0 && outstanding == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
